/* design/stq_pkg.sv */
package stq_pkg;

   localparam int STQ_QUEUE_DEPTH = 16;

   localparam int TAG_W    = 16;
   localparam int DELAY_W  = 16;
   localparam int EXPIRY_W = 32;
   localparam int COUNT_W  = 9;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_TAKE   = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [EXPIRY_W-1:0] expiry;
      logic [DELAY_W-1:0]  delay;
      logic [TAG_W-1:0]    tag;
   } entry_type;

   // Alarm on its way down the list; placed means it is a displaced entry
   // that shifts unconditionally.
   typedef struct packed {
      logic      valid;
      logic      placed;
      entry_type entry;
   } token_type;

endpackage

/* design/stq_cell.sv */
module stq_cell
   import stq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_up,
   input  logic      up_valid,
   input  entry_type up_entry,
   input  token_type tok_in,
   output token_type tok_out,
   output logic      cell_valid,
   output entry_type cell_entry
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   token_type tok_ff, tok_in_next;
   logic [EXPIRY_W-1:0] diff;
   logic      hit;
   logic      take;

   // Held entry at or after the travelling alarm, wrap-aware; an empty cell always takes.
   assign diff = entry_ff.expiry - tok_in.entry.expiry;
   assign hit  = !valid_ff || !diff[EXPIRY_W-1];
   assign take = tok_in.valid && (tok_in.placed || hit);

   always_comb begin
      valid_in    = valid_ff;
      entry_in    = entry_ff;
      tok_in_next = '0;
      if (shift_up) begin
         valid_in = up_valid;
         entry_in = up_entry;
      end else if (take) begin
         valid_in           = 1'b1;
         entry_in           = tok_in.entry;
         tok_in_next.valid  = valid_ff;
         tok_in_next.placed = 1'b1;
         tok_in_next.entry  = entry_ff;
      end else if (tok_in.valid) begin
         tok_in_next = tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      entry_ff      <= entry_in;
      tok_ff.placed <= tok_in_next.placed;
      tok_ff.entry  <= tok_in_next.entry;
   end

   assign tok_out    = tok_ff;
   assign cell_valid = valid_ff;
   assign cell_entry = entry_ff;

endmodule

/* design/sorted_timer_queue_core.sv */
// Channel  Direction  tuser              tdata
// req      in         cmd[1:0]           delay_seconds[15:0], alarm_label[31:16]
// rsp      out        status[1:0]        head_tag[15:0], head_delay[31:16],
//                                        wait_seconds[47:32], queue_count[56:48]
//
// Tick, take and unused commands set no busy count. An insert walks down the
// cell chain one cell a cycle, so it holds off the next request while it
// passes the alarms held before it. The result is formed on acceptance and
// kept in an output register, so a stalled rsp side blocks only the next
// request. Synchronous reset empties the list and clears the clock.
module sorted_timer_queue_core
   import stq_pkg::*;
#(
   parameter int QUEUE_DEPTH = STQ_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // delay_seconds, alarm_label
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // head_tag, head_delay, wait_seconds, queue_count
   output logic [1:0]  rsp_tuser    // status
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [EXPIRY_W-1:0] now_ff, now_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff, status_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [15:0]         wait_ff, wait_in;

   logic                accept;
   logic [1:0]          cmd;
   logic                do_insert;
   logic                do_take;
   logic                full;
   logic [EXPIRY_W-1:0] head_diff;

   token_type           tok_chain [QUEUE_DEPTH+1];
   logic                cell_valid [QUEUE_DEPTH];
   entry_type           cell_entry [QUEUE_DEPTH];

   assign cmd        = req_tuser;
   assign req_tready = (busy_ff == '0) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign do_insert  = accept && (cmd == CMD_INSERT) && !full;
   assign do_take    = accept && (cmd == CMD_TAKE) && (count_ff != '0);
   assign head_diff  = cell_entry[0].expiry - now_ff;

   always_comb begin
      tok_chain[0].valid        = do_insert;
      tok_chain[0].placed       = 1'b0;
      tok_chain[0].entry.expiry = now_ff + EXPIRY_W'(req_tdata[15:0]);
      tok_chain[0].entry.delay  = req_tdata[15:0];
      tok_chain[0].entry.tag    = req_tdata[31:16];
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      up_valid;
      entry_type up_entry;
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign up_valid = 1'b0;
         assign up_entry = '0;
      end else begin : g_mid
         assign up_valid = cell_valid[i+1];
         assign up_entry = cell_entry[i+1];
      end
      stq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_up   (do_take),
         .up_valid   (up_valid),
         .up_entry   (up_entry),
         .tok_in     (tok_chain[i]),
         .tok_out    (tok_chain[i+1]),
         .cell_valid (cell_valid[i]),
         .cell_entry (cell_entry[i])
      );
   end

   always_comb begin
      now_in       = now_ff;
      count_in     = count_ff;
      busy_in      = (busy_ff != '0) ? busy_ff - 1'b1 : busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      tag_in       = tag_ff;
      delay_in     = delay_ff;
      wait_in      = wait_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_DONE;
         tag_in       = '0;
         delay_in     = '0;
         wait_in      = '0;
         case (cmd)
            CMD_TICK: begin
               now_in = now_ff + 1'b1;
            end
            CMD_INSERT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
                  busy_in  = count_ff;
               end
            end
            CMD_TAKE: begin
               if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
                  wait_in   = 16'd1;
               end else begin
                  count_in = count_ff - 1'b1;
                  tag_in   = cell_entry[0].tag;
                  delay_in = cell_entry[0].delay;
                  // Expired head waits zero; long waits saturate.
                  if (head_diff[EXPIRY_W-1] || head_diff == '0) begin
                     wait_in = '0;
                  end else if (head_diff[EXPIRY_W-1:16] != '0) begin
                     wait_in = '1;
                  end else begin
                     wait_in = head_diff[15:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         count_ff     <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      tag_ff    <= tag_in;
      delay_ff  <= delay_in;
      wait_ff   <= wait_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {7'd0, COUNT_W'(count_ff), wait_ff, delay_ff, tag_ff};

   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (busy_ff != '0) |-> !req_tready)
      else $error("request taken while an insert is still travelling");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("alarm count beyond queue depth");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not raise the count");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !tok_chain[QUEUE_DEPTH].valid)
      else $error("alarm pushed off the end of the list");

   a_head_matches: assert property (@(posedge clock) disable iff (reset)
      (busy_ff == '0) |-> (cell_valid[0] == (count_ff != '0)))
      else $error("head cell validity disagrees with count");

endmodule

/* tb/alarm_queue_checker.sv */
`timescale 1ns / 1ps

module alarm_queue_checker
   import stq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // delay_seconds, alarm_label
   input  logic [1:0]  req_tuser,   // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // head_tag, head_delay, wait_seconds, queue_count
   input  logic [1:0]  rsp_tuser,   // status
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [1:0]         status;
      logic [TAG_W-1:0]   tag;
      logic [DELAY_W-1:0] delay;
      logic [15:0]        wait_s;
      logic [COUNT_W-1:0] count;
   } outcome_type;

   logic [EXPIRY_W-1:0] now_seconds;
   logic [EXPIRY_W-1:0] alarm_expiry [STQ_QUEUE_DEPTH];
   logic [DELAY_W-1:0]  alarm_delay  [STQ_QUEUE_DEPTH];
   logic [TAG_W-1:0]    alarm_label  [STQ_QUEUE_DEPTH];
   int                  held;
   outcome_type         awaited_outcomes [$];
   int                  errors = 0;

   // Apply one request to the predicted alarm list and return its outcome.
   task automatic advance_alarm_list(input logic [1:0] cmd, input logic [DELAY_W-1:0] dly,
                                     input logic [TAG_W-1:0] tag, output outcome_type res);
      logic [EXPIRY_W-1:0] due;
      logic [EXPIRY_W-1:0] gap;
      int                  pos;
      res = '0;
      case (cmd)
         CMD_TICK: begin
            now_seconds = now_seconds + 1;
         end
         CMD_INSERT: begin
            if (held >= STQ_QUEUE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               due = now_seconds + EXPIRY_W'(dly);
               pos = held;
               for (int i = 0; i < held; i++) begin
                  gap = alarm_expiry[i] - due;
                  if (!gap[EXPIRY_W-1]) begin
                     pos = i;
                     break;
                  end
               end
               for (int i = held; i > pos; i--) begin
                  alarm_expiry[i] = alarm_expiry[i-1];
                  alarm_delay[i]  = alarm_delay[i-1];
                  alarm_label[i]  = alarm_label[i-1];
               end
               alarm_expiry[pos] = due;
               alarm_delay[pos]  = dly;
               alarm_label[pos]  = tag;
               held++;
            end
         end
         CMD_TAKE: begin
            if (held == 0) begin
               res.status = STATUS_EMPTY;
               res.wait_s = 16'd1;
            end else begin
               gap = alarm_expiry[0] - now_seconds;
               res.tag   = alarm_label[0];
               res.delay = alarm_delay[0];
               if (gap == 0 || gap[EXPIRY_W-1])
                  res.wait_s = 16'd0;
               else if (gap > 32'h0000_FFFF)
                  res.wait_s = 16'hFFFF;
               else
                  res.wait_s = gap[15:0];
               for (int i = 0; i + 1 < held; i++) begin
                  alarm_expiry[i] = alarm_expiry[i+1];
                  alarm_delay[i]  = alarm_delay[i+1];
                  alarm_label[i]  = alarm_label[i+1];
               end
               held--;
            end
         end
         default: ;
      endcase
      res.count = COUNT_W'(held);
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      outcome_type want;
      outcome_type got;
      if (reset) begin
         now_seconds = '0;
         held        = 0;
         awaited_outcomes.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            advance_alarm_list(req_tuser, req_tdata[15:0], req_tdata[31:16], want);
            awaited_outcomes.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.tag    = rsp_tdata[15:0];
            got.delay  = rsp_tdata[31:16];
            got.wait_s = rsp_tdata[47:32];
            got.count  = rsp_tdata[56:48];
            if (awaited_outcomes.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected, actual %0h", $time, got);
            end else begin
               want = awaited_outcomes.pop_front();
               report_field("status", want.status, got.status);
               report_field("head_tag", want.tag, got.tag);
               report_field("head_delay", want.delay, got.delay);
               report_field("wait_seconds", want.wait_s, got.wait_s);
               report_field("queue_count", want.count, got.count);
            end
         end
      end
      fail_count <= errors;
      pending    <= awaited_outcomes.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench
   import stq_pkg::*;
();

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // delay_seconds, alarm_label
   logic [1:0]  req_tuser;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // head_tag, head_delay, wait_seconds, queue_count
   logic [1:0]  rsp_tuser;   // status
   int          fail_count;
   int          pending;
   int          max_gap;

   sorted_timer_queue_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   alarm_queue_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[sorted_timer_queue_core] ERROR");
      $finish;
   end

   // Hold the request for a random gap, then offer it until accepted.
   task automatic offer_request(input logic [1:0] cmd, input logic [15:0] dly,
                                input logic [15:0] tag);
      int gap;
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {tag, dly};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [15:0] pick_delay();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return 16'($urandom_range(0, 8));
      else if (roll == 4)
         return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      else
         return 16'($urandom_range(0, 65535));
   endfunction

   // Receiver: random stalls, quiet stretches, and one long hold-off.
   initial begin : receiver
      int accepted;
      int hold;
      bit quiet;
      bit held_off;
      accepted = 0;
      quiet    = 1'b0;
      held_off = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (accepted % 32 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         if (accepted == 200 && !held_off) begin
            hold     = 400;
            held_off = 1'b1;
         end else begin
            hold = quiet ? 0 : $urandom_range(0, 14);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         accepted++;
      end
   end

   initial begin : stimulus
      int mode;
      int roll;
      logic [1:0] cmd;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_TICK;
      max_gap    = 14;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty take, unused command, expiry edges, equal expiries
      offer_request(CMD_TAKE, 16'h0000, 16'h0000);
      offer_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
      offer_request(CMD_INSERT, 16'h0000, 16'hFFFF);
      offer_request(CMD_TAKE, 16'h0000, 16'h0000);
      offer_request(CMD_INSERT, 16'h0002, 16'h1234);
      offer_request(CMD_TICK, 16'hFFFF, 16'hFFFF);
      offer_request(CMD_TICK, 16'h0000, 16'h0000);
      offer_request(CMD_TICK, 16'h0000, 16'h0000);
      offer_request(CMD_TAKE, 16'h0000, 16'h0000);
      offer_request(CMD_INSERT, 16'h0005, 16'h00AA);
      offer_request(CMD_INSERT, 16'h0005, 16'h0055);
      offer_request(CMD_INSERT, 16'hFFFF, 16'h0000);
      offer_request(CMD_INSERT, 16'h0001, 16'hFFFF);
      offer_request(CMD_TAKE, 16'h0000, 16'h0000);
      offer_request(CMD_TAKE, 16'h0000, 16'h0000);
      offer_request(CMD_TAKE, 16'h0000, 16'h0000);
      offer_request(CMD_TAKE, 16'hFFFF, 16'hFFFF);
      offer_request(CMD_TAKE, 16'h0000, 16'h0000);
      offer_request(CMD_UNUSED, 16'h0000, 16'h0000);

      // random bursts: fill, drain or mixed, each with its own idling style
      for (int burst = 0; burst < 20; burst++) begin
         mode    = $urandom_range(0, 2);
         max_gap = ($urandom_range(0, 2) == 0) ? 0 : 14;
         for (int n = 0; n < 40; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
               cmd = CMD_UNUSED;
            else if (roll < 26)
               cmd = CMD_TICK;
            else if (mode == 0)
               cmd = (roll < 86) ? CMD_INSERT : CMD_TAKE;
            else if (mode == 1)
               cmd = (roll < 40) ? CMD_INSERT : CMD_TAKE;
            else
               cmd = (roll < 63) ? CMD_INSERT : CMD_TAKE;
            offer_request(cmd, pick_delay(), 16'($urandom_range(0, 65535)));
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (STQ_QUEUE_DEPTH + 8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[sorted_timer_queue_core] OK");
      else
         $display("[sorted_timer_queue_core] ERROR");
      $finish;
   end

endmodule

/* filelist.f */
design/stq_pkg.sv
design/stq_cell.sv
design/sorted_timer_queue_core.sv
tb/alarm_queue_checker.sv
tb/testbench.sv
